@@ rtl/ethp_pkg.sv @@
// ----------------------------------------------------------------------------
// ethp_pkg: shared types and constants for the event time min heap
// Entry layout, request kinds, status codes, sequencer states.
// ----------------------------------------------------------------------------
package ethp_pkg;

  localparam int unsigned EntryW = 57;

  typedef struct packed {
    logic [7:0]  tag;
    logic        player;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [31:0] time_v;
  } entry_t;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_POP    = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_FIND   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_MOVE_RD,
    S_MOVE_WR,
    S_POP_RD,
    S_POP_CAP,
    S_PASS_START,
    S_RD_C,
    S_RD_P,
    S_CMP,
    S_SWAP_P,
    S_DONE
  } state_e;

endpackage

@@ rtl/ethp_slot_ram.sv @@
// ----------------------------------------------------------------------------
// ethp_slot_ram: single-port entry store
// One write and one registered read per cycle, both at the same address.
// ----------------------------------------------------------------------------
module ethp_slot_ram
  import ethp_pkg::*;
#(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  entry_t           wdata_i,
  output entry_t           rdata_o
);

  entry_t mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

@@ rtl/event_time_min_heap.sv @@
// ----------------------------------------------------------------------------
// event_time_min_heap: priority queue ordered by event time
// ----------------------------------------------------------------------------
// One request in on the s_axis group, one result out on m_axis per request.
// Request kinds: insert, pop minimum, delete by row/col, find player.
// After insert, pop and delete the heap is repaired by full passes from the
// last slot down to slot 1, each comparing a slot with its parent and swapping
// when the parent's time is strictly greater; passes repeat until one makes no
// swap. All slot traffic goes through one single-port RAM with a registered
// read, so a pass visits the slots one at a time: read the slot, read its
// parent, compare, and on a swap write both back. A scan for delete or find
// reads and checks one slot at a time. A rejected request's result is valid in
// the cycle after it is accepted. s_axis_tready is high only while the
// sequencer is idle. The result sits in an output register until taken; the
// sequencer returns to idle only once it is accepted. Reset empties the queue
// and sets max_entries to 64; slot contents are not cleared.
// cfg_we_i writes max_entries; do so only while idle.
// ----------------------------------------------------------------------------
module event_time_min_heap
  import ethp_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // kind[1:0], event_time[33:2], row[41:34], col[49:42], is_player[50],
  // tag[58:51], zero fill
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], out_time[33:2], out_row[41:34], out_col[49:42],
  // out_player[50], out_tag[58:51], player_index[64:59], occupancy[71:65]
  output logic [71:0] m_axis_tdata
);

  localparam int unsigned AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);

  state_e state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [6:0]       max_q;
  logic [AddrW-1:0] i_q, i_d;
  logic [AddrW-1:0] addr;
  logic             we;
  entry_t           wdata, rdata;
  entry_t           ent_q, ent_d, ec_q, ec_d;
  logic [1:0]       kind_q, kind_d;
  logic [7:0]       krow_q, krow_d, kcol_q, kcol_d;
  logic             swapped_q, swapped_d;
  status_e          st_q, st_d;
  entry_t           oent_q, oent_d;
  logic [AddrW-1:0] pidx_q, pidx_d;
  logic [CntW-1:0]  limit;
  logic [AddrW-1:0] par;
  logic             in_acc;

  ethp_slot_ram #(.Depth(CAPACITY), .AddrW(AddrW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  always_comb begin
    if ({{(32-7){1'b0}}, max_q} < CAPACITY) limit = CntW'(max_q);
    else limit = CntW'(CAPACITY);
  end

  assign par = (i_q - AddrW'(1)) >> 1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (state_q == S_DONE);

  always_comb begin
    logic [63:0] pi, oc;
    pi = 64'(pidx_q);
    oc = 64'(cnt_q);
    m_axis_tdata = {oc[6:0], pi[5:0], oent_q.tag, oent_q.player,
                    oent_q.col, oent_q.row, oent_q.time_v, st_q};
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; i_d = i_q; ent_d = ent_q; ec_d = ec_q;
    kind_d = kind_q; krow_d = krow_q; kcol_d = kcol_q; swapped_d = swapped_q;
    st_d = st_q; oent_d = oent_q; pidx_d = pidx_q;
    we = 1'b0; addr = i_q; wdata = ent_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          kind_d = s_axis_tdata[1:0];
          ent_d = {s_axis_tdata[58:51], s_axis_tdata[50], s_axis_tdata[49:42],
                   s_axis_tdata[41:34], s_axis_tdata[33:2]};
          krow_d = s_axis_tdata[41:34];
          kcol_d = s_axis_tdata[49:42];
          st_d = ST_OK; oent_d = '0; pidx_d = '0; i_d = '0;
          case (kind_e'(s_axis_tdata[1:0]))
            KIND_INSERT: begin
              if (cnt_q >= limit) begin
                st_d = ST_FULL; state_d = S_DONE;
              end else begin
                i_d = cnt_q[AddrW-1:0];
                state_d = S_MOVE_WR;
              end
            end
            KIND_POP: begin
              if (cnt_q == '0) begin
                st_d = ST_EMPTY; state_d = S_DONE;
              end else state_d = S_POP_RD;
            end
            default: begin
              if (cnt_q == '0) begin
                st_d = ST_NOTFOUND; state_d = S_DONE;
              end else state_d = S_SCAN_RD;
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        addr = i_q; state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (kind_e'(kind_q) == KIND_FIND && rdata.player) begin
          pidx_d = i_q; state_d = S_DONE;
        end else if (kind_e'(kind_q) == KIND_DELETE && rdata.row == krow_q &&
                     rdata.col == kcol_q) begin
          state_d = S_MOVE_RD;
        end else if (CntW'(i_q) + CntW'(1) >= cnt_q) begin
          st_d = ST_NOTFOUND; state_d = S_DONE;
        end else begin
          i_d = i_q + AddrW'(1); state_d = S_SCAN_RD;
        end
      end
      S_POP_RD: begin
        addr = '0; state_d = S_POP_CAP;
      end
      S_POP_CAP: begin
        oent_d = rdata; i_d = '0; state_d = S_MOVE_RD;
      end
      S_MOVE_RD: begin
        addr = AddrW'(cnt_q - CntW'(1)); state_d = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        we = 1'b1; addr = i_q;
        if (kind_e'(kind_q) == KIND_INSERT) begin
          wdata = ent_q; cnt_d = cnt_q + CntW'(1);
        end else begin
          wdata = rdata; cnt_d = cnt_q - CntW'(1);
        end
        state_d = S_PASS_START;
      end
      S_PASS_START: begin
        swapped_d = 1'b0;
        if (cnt_q <= CntW'(1)) state_d = S_DONE;
        else begin
          i_d = AddrW'(cnt_q - CntW'(1)); state_d = S_RD_C;
        end
      end
      S_RD_C: begin
        addr = i_q; state_d = S_RD_P;
      end
      S_RD_P: begin
        ec_d = rdata; addr = par; state_d = S_CMP;
      end
      S_CMP: begin
        if (rdata.time_v > ec_q.time_v) begin
          we = 1'b1; addr = i_q; wdata = rdata; swapped_d = 1'b1;
          state_d = S_SWAP_P;
        end else if (i_q == AddrW'(1)) begin
          state_d = swapped_q ? S_PASS_START : S_DONE;
        end else begin
          i_d = i_q - AddrW'(1); state_d = S_RD_C;
        end
      end
      S_SWAP_P: begin
        we = 1'b1; addr = par; wdata = ec_q;
        if (i_q == AddrW'(1)) state_d = S_PASS_START;
        else begin
          i_d = i_q - AddrW'(1); state_d = S_RD_C;
        end
      end
      S_DONE: begin
        if (m_axis_tready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      max_q <= 7'd64;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      if (cfg_we_i) max_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; ent_q <= ent_d; ec_q <= ec_d; kind_q <= kind_d;
    krow_q <= krow_d; kcol_q <= kcol_d; swapped_q <= swapped_d;
    st_q <= st_d; oent_q <= oent_d; pidx_q <= pidx_d;
  end

endmodule

@@ rtl/ethp_checker.sv @@
// ----------------------------------------------------------------------------
// ethp_checker: port-level checks for the event time min heap
// ----------------------------------------------------------------------------
module ethp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);

  // one request at a time: no new request while a result is pending
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");

  // accepting a request drops ready
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("ready after request");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");

  // occupancy reported with a result never exceeds 64
  a_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[71:65] <= 7'd64) else $error("occupancy range");

endmodule

bind event_time_min_heap ethp_checker u_ethp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
